// ----- src/fnorm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types for the fraction normaliser: word structs and the
// controller/datapath command and status groups. No dependencies.
package fnorm_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned RevW  = 34;
    // reciprocal of ten, scaled by 2^35
    localparam logic [WordW-1:0] RecipTen = 32'hCCCC_CCCD;
    localparam int unsigned RecipShift = 35;

    typedef struct packed {
        logic signed [WordW-1:0] numerator_in;
        logic signed [WordW-1:0] denominator_in;
    } in_word_t;

    typedef struct packed {
        logic signed [WordW-1:0] reduced_numerator;
        logic signed [WordW-1:0] reduced_denominator;
        logic                    numerator_palindrome;
        logic                    denominator_palindrome;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic pal_load;
        logic pal_mul;
        logic pal_dig;
        logic sel_den;
    } fn_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic cnt_last;
        logic digit_last;
    } fn_status_t;

endpackage

// ----- src/fnorm_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: binary gcd, two restoring dividers and a digit reverser.
// Depends on fnorm_pkg.
module fnorm_datapath (
    input  logic                 clk,
    input  fnorm_pkg::in_word_t  request,
    input  fnorm_pkg::fn_cmd_t   cmd,
    output fnorm_pkg::fn_status_t status,
    output fnorm_pkg::out_word_t result
);

    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic [4:0]  k_reg, k_next;
    logic        flip_reg;
    logic [31:0] g_reg;
    logic [31:0] qn_reg, qd_reg, remn_reg, remd_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] pv_reg, orig_reg;
    logic [fnorm_pkg::RevW-1:0] rev_reg, rev_next;
    logic [63:0] prod_reg;
    logic        npal_reg, dpal_reg;

    logic [31:0] mn, md, shn, shd, quo, digit_full;
    logic [32:0] subn, subd;

    // operand magnitudes
    assign mn = request.numerator_in[31]   ? 32'(-request.numerator_in)   : request.numerator_in;
    assign md = request.denominator_in[31] ? 32'(-request.denominator_in) : request.denominator_in;

    // one binary gcd step
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (!a_reg[0] && !b_reg[0])
        begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + 5'd1;
        end
        else if (!a_reg[0])
            a_next = a_reg >> 1;
        else if (!b_reg[0])
            b_next = b_reg >> 1;
        else if (a_reg >= b_reg)
            a_next = a_reg - b_reg;
        else
            b_next = b_reg - a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            k_reg    <= '0;
            flip_reg <= request.numerator_in[31] ^ request.denominator_in[31];
            if (mn == '0 || md == '0)
            begin
                a_reg <= 32'd1;
                b_reg <= '0;
            end
            else
            begin
                a_reg <= mn;
                b_reg <= md;
            end
            qn_reg <= mn;
            qd_reg <= md;
        end
        else if (cmd.gcd_step)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end
        if (cmd.div_start)
        begin
            g_reg    <= (a_reg | b_reg) << k_reg;
            remn_reg <= '0;
            remd_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            remn_reg <= subn[32] ? shn : subn[31:0];
            remd_reg <= subd[32] ? shd : subd[31:0];
            qn_reg   <= {qn_reg[30:0], ~subn[32]};
            qd_reg   <= {qd_reg[30:0], ~subd[32]};
            cnt_reg  <= cnt_reg + 5'd1;
        end
    end

    // restoring division, both quotients in step
    assign shn  = {remn_reg[30:0], qn_reg[31]};
    assign shd  = {remd_reg[30:0], qd_reg[31]};
    assign subn = {1'b0, shn} - {1'b0, g_reg};
    assign subd = {1'b0, shd} - {1'b0, g_reg};

    // digit step: quotient by ten through the reciprocal product
    assign quo        = 32'(prod_reg[63:fnorm_pkg::RecipShift]);
    assign digit_full = pv_reg - ((quo << 3) + (quo << 1));
    assign rev_next   = (rev_reg << 3) + (rev_reg << 1) + fnorm_pkg::RevW'(digit_full[3:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.pal_load)
        begin
            pv_reg   <= cmd.sel_den ? qd_reg : qn_reg;
            orig_reg <= cmd.sel_den ? qd_reg : qn_reg;
            rev_reg  <= '0;
        end
        else if (cmd.pal_mul)
            prod_reg <= 64'(pv_reg) * 64'(fnorm_pkg::RecipTen);
        else if (cmd.pal_dig)
        begin
            pv_reg  <= quo;
            rev_reg <= rev_next;
            if (quo == '0)
            begin
                if (cmd.sel_den)
                    dpal_reg <= (rev_next == fnorm_pkg::RevW'(orig_reg));
                else
                    npal_reg <= (rev_next == fnorm_pkg::RevW'(orig_reg));
            end
        end
    end

    assign status.gcd_done   = (a_reg == '0) || (b_reg == '0);
    assign status.cnt_last   = (cnt_reg == 5'd31);
    assign status.digit_last = (quo == '0);

    assign result.reduced_numerator      = flip_reg ? -$signed(qn_reg) : $signed(qn_reg);
    assign result.reduced_denominator    = $signed(qd_reg);
    assign result.numerator_palindrome   = npal_reg;
    assign result.denominator_palindrome = dpal_reg;

endmodule

// ----- src/fnorm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences gcd, division and palindrome phases.
// Depends on fnorm_pkg.
module fnorm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  fnorm_pkg::fn_status_t status,
    output fnorm_pkg::fn_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PLD  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIG  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel_den = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = 1'b0;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_last)
                    state_next = S_PLD;
            end
            S_PLD:
            begin
                cmd.pal_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.pal_mul = 1'b1;
                state_next  = S_DIG;
            end
            S_DIG:
            begin
                cmd.pal_dig = 1'b1;
                if (!status.digit_last)
                    state_next = S_MUL;
                else if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_PLD;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

// ----- src/fraction_normalizer.sv -----
`timescale 1ns / 1ps
// Top level of the fraction normaliser: controller plus datapath.
// Depends on fnorm_pkg, fnorm_ctrl and fnorm_datapath.
//
// Usage:
//   A word (numerator_in, denominator_in) is taken on request at a rising
//   edge with start high and busy low. busy stays high until the result has
//   been shown. The result word (reduced fraction with sign on the
//   numerator, plus a decimal palindrome flag for each term) sits on result
//   for the single cycle in which done is high; the receiver must take it
//   then, it cannot hold it off.
//   Steps: a load, binary gcd steps (shifts plus subtractions) until one
//   operand is zero, a set-up step, restoring division of both terms at
//   once, then for each term a load step plus a multiply step and a digit
//   step per decimal digit (up to 10 digits each), and an output step. The
//   gcd loop and the digit loops vary with the operands, and the
//   reciprocal multiplier is shared by both terms; one word is worked on at
//   a time.
//   Reset (rst_n low) returns the controller to idle at once; a word in
//   progress is dropped.
module fraction_normalizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fnorm_pkg::in_word_t  request,
    output logic                 busy,
    output logic                 done,
    output fnorm_pkg::out_word_t result
);

    fnorm_pkg::fn_cmd_t    cmd;
    fnorm_pkg::fn_status_t status;

    fnorm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    fnorm_datapath u_dp (
        .clk     (clk),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

// ----- src/fnorm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the fraction normaliser, bound to the top level.
// Depends on fnorm_pkg.
module fnorm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input fnorm_pkg::out_word_t result
);

    // a word accepted makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result only while busy
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done while idle");

    // a result is shown for one cycle and frees the block
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done && !busy)
        else $error("done not single cycle");

    // denominator of a shown result is never negative unless it wrapped
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.reduced_denominator[31] |-> result.reduced_denominator[30:0] == '0)
        else $error("negative denominator");

endmodule

bind fraction_normalizer fnorm_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- tb/fraction_checker.sv -----
`timescale 1ns / 1ps
// Checker for the fraction normaliser: predicts each reduced fraction from
// accepted request words and compares result words. Depends on fnorm_pkg.
module fraction_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  fnorm_pkg::in_word_t  request,
    input  logic                 done,
    input  fnorm_pkg::out_word_t result,
    output int                   fail_count,
    output int                   pending
);
    import fnorm_pkg::*;

    out_word_t reduced_q[$];

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // digit-by-digit palindrome test on an unsigned magnitude
    function automatic logic is_palindrome(input logic [31:0] v);
        logic [3:0] dg[10];
        int cnt;
        int i;
        cnt = 0;
        do
        begin
            dg[cnt] = 4'(v % 10);
            cnt++;
            v = v / 10;
        end
        while (v != 0 && cnt < 10);
        for (i = 0; i < cnt / 2; i++)
        begin
            if (dg[i] != dg[cnt - 1 - i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic out_word_t reduce_fraction(input in_word_t w);
        out_word_t r;
        logic [31:0] mn, md, a, b, t, g, qn;
        mn = magnitude(w.numerator_in);
        md = magnitude(w.denominator_in);
        g = 32'd1;
        if (mn != 0 && md != 0)
        begin
            a = mn;
            b = md;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            g = a;
        end
        qn = mn / g;
        r.reduced_numerator = (w.numerator_in[31] != w.denominator_in[31]) ? -qn : qn;
        r.reduced_denominator = md / g;
        r.numerator_palindrome = is_palindrome(magnitude(r.reduced_numerator));
        r.denominator_palindrome = is_palindrome(magnitude(r.reduced_denominator));
        return r;
    endfunction

    assign pending = reduced_q.size();

    // predict on accepted word, compare on done strobe
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (start && !busy)
                reduced_q.push_back(reduce_fraction(request));
            if (done)
            begin
                if (reduced_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = reduced_q.pop_front();
                    if (result !== exp_w)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp n=%0d d=%0d pn=%b pd=%b got n=%0d d=%0d pn=%b pd=%b",
                                exp_w.reduced_numerator, exp_w.reduced_denominator,
                                exp_w.numerator_palindrome, exp_w.denominator_palindrome,
                                result.reduced_numerator, result.reduced_denominator,
                                result.numerator_palindrome, result.denominator_palindrome);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the fraction normaliser testbench: clock, reset, request stimulus
// and verdict. Depends on fnorm_pkg, fraction_normalizer, fraction_checker.
module testbench;
    import fnorm_pkg::*;

    localparam int RandomWords = 700;
    localparam int CycleLimit = 1000000;

    logic clk;
    logic rst_n;
    logic start;
    in_word_t request;
    logic busy;
    logic done;
    out_word_t result;
    int fail_count;
    int pending;
    int cycles;

    in_word_t directed[$];

    fraction_normalizer DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .done(done), .result(result)
    );

    fraction_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 2000) - 1000;
            2: return {$urandom_range(0, 1) ? 32'hFFFF_FF00 : 32'h0} | $urandom_range(0, 255);
            3: return 32'h8000_0000 | $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_word_t make_word();
        in_word_t w;
        logic [31:0] k;
        // share a common factor often so reduction does real work
        if ($urandom_range(0, 2) == 0)
        begin
            k = $urandom_range(1, 5000);
            w.numerator_in = $signed($urandom_range(0, 400000) - 200000) * $signed(k);
            w.denominator_in = $signed($urandom_range(0, 400000) - 200000) * $signed(k);
        end
        else
        begin
            w.numerator_in = rand_value();
            w.denominator_in = rand_value();
        end
        return w;
    endfunction

    // hold one word on the request until it is taken; start stays high
    task automatic send_word(input in_word_t w);
        request <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int i;
        int burst;
        int gap;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, zeros, signs, palindromes
        directed.push_back({32'sd0, 32'sd0});
        directed.push_back({32'sd0, 32'sd7});
        directed.push_back({32'sd0, -32'sd7});
        directed.push_back({32'sd5, 32'sd0});
        directed.push_back({-32'sd5, 32'sd0});
        directed.push_back({32'sd6, 32'sd4});
        directed.push_back({-32'sd6, 32'sd4});
        directed.push_back({32'sd6, -32'sd4});
        directed.push_back({-32'sd6, -32'sd4});
        directed.push_back({32'sh7FFF_FFFF, 32'sd1});
        directed.push_back({32'sh8000_0001, 32'sh7FFF_FFFF});
        directed.push_back({32'sh8000_0000, 32'sd1});
        directed.push_back({32'sh8000_0000, -32'sd1});
        directed.push_back({32'sd1, 32'sh8000_0000});
        directed.push_back({32'sh8000_0000, 32'sh8000_0000});
        directed.push_back({32'sh8000_0000, 32'sd0});
        directed.push_back({32'sd1234321, 32'sd2});
        directed.push_back({32'sd2147447412, 32'sd1});
        directed.push_back({-32'sd12321, 32'sd10});
        directed.push_back({32'sd1000000001, 32'sd1999999998});
        directed.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        foreach (directed[j])
            send_word(directed[j]);
        start <= 1'b0;

        // pause until everything drains
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // random bursts with random gaps
        i = 0;
        while (i < RandomWords)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if (i < RandomWords)
                begin
                    send_word(make_word());
                    i++;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
            if (gap != 0)
                start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (gap == 0)
            start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
